[design/n2dc_pkg.sv]
`default_nettype none

package n2dc_pkg;

  localparam int HALF_W     = 1;
  localparam int HALF_H     = 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int MASK_COLS = 2 * HALF_W + 1;
  localparam int MASK_ROWS = 2 * HALF_H + 1;
  localparam int MASK_SIZE = MASK_COLS * MASK_ROWS;

  // word fields
  localparam int CMD_W      = 2;
  localparam int PIX_W      = 8;
  localparam int CIDX_W     = 4;
  localparam int COEF_W     = 16;
  localparam int OUT_W      = 28;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int NORM_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // internal widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int LEAD_W = $clog2(HALF_H * MAX_WIDTH + HALF_W + 1);
  localparam int LINE_W = 2 * HALF_H * PIXEL_BITS;
  localparam int K_W    = $clog2(MASK_SIZE);
  localparam int KCNT_W = $clog2(MASK_SIZE + 2);
  localparam int PROD_W = PIXEL_BITS + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + $clog2(MASK_SIZE);
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W  = ((SUM_W > OUT_W) ? SUM_W : OUT_W) + 1;

  localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_NORM   = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_NORM   = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

[design/n2dc_if.sv]
`default_nettype none

interface n2dc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [n2dc_pkg::CMD_W-1:0]   command;
  logic        [n2dc_pkg::PIX_W-1:0]   pixel_value;
  logic        [n2dc_pkg::CIDX_W-1:0]  coef_index;
  logic signed [n2dc_pkg::COEF_W-1:0]  coef_value;

  modport source (output valid, command, pixel_value, coef_index, coef_value,
                  input ready);
  modport sink (input valid, command, pixel_value, coef_index, coef_value,
                output ready);
endinterface

interface n2dc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [n2dc_pkg::OUT_W-1:0]  filtered_value;
  logic                               result_valid;

  modport source (output valid, filtered_value, result_valid, input ready);
  modport sink (input valid, filtered_value, result_valid, output ready);
endinterface

interface n2dc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [n2dc_pkg::CFG_IDX_W-1:0]      index;
  logic [n2dc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/normalized_2d_convolution_unit.sv]
// channel   dir  word contents
// in_bus    in   command, pixel_value, coef_index, coef_value
// out_bus   out  filtered_value, result_valid
// cfg_bus   in   index (0 width, 1 height, 2 norm), data
//
// Coefficient load or unused command: taken in S_IDLE. Pixel or flush: S_LOAD, then
// S_OUT for a border or pre-image centre; an inner centre adds S_MAC, S_PREP, S_DIV
// and S_FIN, for the shared multiply-accumulate and the one-bit-per-cycle divider.
// Line store: one RMW per pixel, column of the previous rows read then written back.
// Reset is synchronous; line and coefficient stores need no clearing pass.
// A result waits in the output register; the next word is taken meanwhile.
`default_nettype none

module normalized_2d_convolution_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  n2dc_in_if.sink      in_bus,
  n2dc_out_if.source   out_bus,
  n2dc_cfg_if.sink     cfg_bus
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MAC, S_PREP, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [n2dc_pkg::WEFF_W-1:0]   width_r, width_nxt;
  logic [n2dc_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic [n2dc_pkg::NORM_W-1:0]   norm_r, norm_nxt;
  logic [n2dc_pkg::LEAD_W-1:0]   delay_r, delay_nxt;
  logic [n2dc_pkg::LEAD_W-1:0]   lead_r, lead_nxt;
  logic [n2dc_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [n2dc_pkg::COL_W-1:0]    cx_r, cx_nxt;
  logic [n2dc_pkg::HEIGHT_W-1:0] cy_r, cy_nxt;
  logic [n2dc_pkg::KCNT_W-1:0]   k_r, k_nxt;
  logic [n2dc_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [n2dc_pkg::PIXEL_BITS-1:0] win_r [n2dc_pkg::MASK_SIZE];
  logic [n2dc_pkg::PIXEL_BITS-1:0] win_nxt [n2dc_pkg::MASK_SIZE];

  logic [n2dc_pkg::COL_W-1:0]        wr_addr_r, wr_addr_nxt;
  logic [n2dc_pkg::PIXEL_BITS-1:0]   px_r, px_nxt;
  logic                              cvalid_r, cvalid_nxt;
  logic                              inner_r, inner_nxt;
  logic [n2dc_pkg::PIXEL_BITS-1:0]   pix_sel_r, pix_sel_nxt;
  logic signed [n2dc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [n2dc_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic                              neg_r, neg_nxt;
  logic [n2dc_pkg::SUM_W-1:0]        quo_r, quo_nxt;
  logic [n2dc_pkg::NORM_W-1:0]       rem_r, rem_nxt;
  logic signed [n2dc_pkg::OUT_W-1:0] res_value_r, res_value_nxt;
  logic                              res_flag_r, res_flag_nxt;
  logic signed [n2dc_pkg::OUT_W-1:0] out_value_r, out_value_nxt;
  logic                              out_flag_r, out_flag_nxt;

  logic [n2dc_pkg::LINE_W-1:0]       line_mem [n2dc_pkg::MAX_WIDTH];
  logic [n2dc_pkg::LINE_W-1:0]       line_rd_r;
  logic signed [n2dc_pkg::COEF_W-1:0] coef_mem [n2dc_pkg::MASK_SIZE];
  logic signed [n2dc_pkg::COEF_W-1:0] coef_rd_r;

  localparam logic signed [n2dc_pkg::CMP_W-1:0] SAT_HI =
    n2dc_pkg::CMP_W'((2 ** (n2dc_pkg::OUT_W - 1)) - 1);
  localparam logic signed [n2dc_pkg::CMP_W-1:0] SAT_LO = ~SAT_HI;

  logic in_fire, cfg_fire, item_fire, coef_wr_en, line_wr_en, out_load;
  logic c_valid, c_inner, c_restart;
  logic [n2dc_pkg::WEFF_W-1:0]     col_inc, cx_inc, cfg_w_eff;
  logic [n2dc_pkg::WIDTH_W-1:0]    cfg_w_raw;
  logic [n2dc_pkg::HEIGHT_W-1:0]   cfg_h_raw;
  logic [n2dc_pkg::NORM_W-1:0]     cfg_n_raw;
  logic [n2dc_pkg::K_W-1:0]        k_idx;
  logic [n2dc_pkg::PIXEL_BITS-1:0] new_col [n2dc_pkg::MASK_ROWS];
  logic [n2dc_pkg::LINE_W-1:0]     line_wr_data;
  logic signed [n2dc_pkg::PIXEL_BITS:0] pix_s;
  logic [n2dc_pkg::NORM_W:0]       div_trial, div_diff;
  logic                            div_ge;
  logic signed [n2dc_pkg::CMP_W-1:0] q_ext, q_signed;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign cfg_fire  = cfg_bus.valid && cfg_bus.ready;
  assign item_fire = in_fire && (in_bus.command == n2dc_pkg::CMD_PIXEL ||
                                 in_bus.command == n2dc_pkg::CMD_FLUSH);
  assign coef_wr_en = in_fire && (in_bus.command == n2dc_pkg::CMD_LOAD) &&
                      (int'(in_bus.coef_index) < n2dc_pkg::MASK_SIZE);
  assign line_wr_en = (state_r == S_LOAD);

  assign out_bus.valid          = out_valid_r;
  assign out_bus.filtered_value = out_value_r;
  assign out_bus.result_valid   = out_flag_r;

  // centre reported by the next pixel or flush word
  assign c_valid = (lead_r == delay_r);
  assign c_inner = c_valid &&
    (cx_r >= n2dc_pkg::COL_W'(n2dc_pkg::HALF_W)) &&
    ((n2dc_pkg::WEFF_W + 1)'(cx_r) + (n2dc_pkg::WEFF_W + 1)'(n2dc_pkg::HALF_W) <
     (n2dc_pkg::WEFF_W + 1)'(width_r)) &&
    (cy_r >= n2dc_pkg::HEIGHT_W'(n2dc_pkg::HALF_H)) &&
    ((n2dc_pkg::HEIGHT_W + 1)'(cy_r) + (n2dc_pkg::HEIGHT_W + 1)'(n2dc_pkg::HALF_H) <
     (n2dc_pkg::HEIGHT_W + 1)'(height_r));
  assign c_restart = c_valid &&
    (n2dc_pkg::WEFF_W'(cx_r) == width_r - n2dc_pkg::WEFF_W'(1)) &&
    (cy_r == height_r - n2dc_pkg::HEIGHT_W'(1));

  assign col_inc = n2dc_pkg::WEFF_W'(col_r) + n2dc_pkg::WEFF_W'(1);
  assign cx_inc  = n2dc_pkg::WEFF_W'(cx_r) + n2dc_pkg::WEFF_W'(1);

  assign cfg_w_raw = cfg_bus.data[n2dc_pkg::WIDTH_W-1:0];
  assign cfg_h_raw = cfg_bus.data[n2dc_pkg::HEIGHT_W-1:0];
  assign cfg_n_raw = cfg_bus.data[n2dc_pkg::NORM_W-1:0];
  assign cfg_w_eff = (cfg_w_raw == '0) ? n2dc_pkg::WEFF_W'(1) :
                     (int'(cfg_w_raw) > n2dc_pkg::MAX_WIDTH) ?
                       n2dc_pkg::WEFF_W'(n2dc_pkg::MAX_WIDTH) :
                       n2dc_pkg::WEFF_W'(cfg_w_raw);

  assign k_idx = (int'(k_r) < n2dc_pkg::MASK_SIZE) ? k_r[n2dc_pkg::K_W-1:0] : '0;
  assign pix_s = $signed({1'b0, pix_sel_r});

  // new column: older rows from the line store, current pixel at the bottom
  always_comb begin
    for (int r = 0; r < n2dc_pkg::MASK_ROWS - 1; r++) begin
      new_col[r] = line_rd_r[r*n2dc_pkg::PIXEL_BITS +: n2dc_pkg::PIXEL_BITS];
    end
    new_col[n2dc_pkg::MASK_ROWS-1] = px_r;
    for (int j = 0; j < 2 * n2dc_pkg::HALF_H; j++) begin
      line_wr_data[j*n2dc_pkg::PIXEL_BITS +: n2dc_pkg::PIXEL_BITS] = new_col[j+1];
    end
  end

  assign div_trial = {rem_r, quo_r[n2dc_pkg::SUM_W-1]};
  assign div_diff  = div_trial - {1'b0, norm_r};
  assign div_ge    = (div_trial >= {1'b0, norm_r});

  assign q_ext    = $signed(n2dc_pkg::CMP_W'(quo_r));
  assign q_signed = neg_r ? -q_ext : q_ext;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    norm_nxt      = norm_r;
    delay_nxt     = delay_r;
    lead_nxt      = lead_r;
    col_nxt       = col_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    k_nxt         = k_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    win_nxt       = win_r;
    wr_addr_nxt   = wr_addr_r;
    px_nxt        = px_r;
    cvalid_nxt    = cvalid_r;
    inner_nxt     = inner_r;
    pix_sel_nxt   = win_r[k_idx];
    prod_nxt      = pix_s * coef_rd_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_value_nxt = res_value_r;
    res_flag_nxt  = res_flag_r;
    out_value_nxt = out_value_r;
    out_flag_nxt  = out_flag_r;

    unique case (state_r)
      S_IDLE: begin
        if (item_fire) begin
          px_nxt      = (in_bus.command == n2dc_pkg::CMD_PIXEL) ?
                        n2dc_pkg::PIXEL_BITS'(in_bus.pixel_value) : '0;
          wr_addr_nxt = col_r;
          cvalid_nxt  = c_valid;
          inner_nxt   = c_inner;
          if (c_restart) begin
            col_nxt  = '0;
            lead_nxt = '0;
            cx_nxt   = '0;
            cy_nxt   = '0;
          end else begin
            col_nxt = (col_inc >= width_r) ? '0 : col_inc[n2dc_pkg::COL_W-1:0];
            if (!c_valid) begin
              lead_nxt = lead_r + n2dc_pkg::LEAD_W'(1);
            end else if (cx_inc >= width_r) begin
              cx_nxt = '0;
              cy_nxt = cy_r + n2dc_pkg::HEIGHT_W'(1);
            end else begin
              cx_nxt = cx_inc[n2dc_pkg::COL_W-1:0];
            end
          end
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        for (int r = 0; r < n2dc_pkg::MASK_ROWS; r++) begin
          for (int c = 0; c < n2dc_pkg::MASK_COLS - 1; c++) begin
            win_nxt[r*n2dc_pkg::MASK_COLS + c] = win_r[r*n2dc_pkg::MASK_COLS + c + 1];
          end
          win_nxt[r*n2dc_pkg::MASK_COLS + n2dc_pkg::MASK_COLS - 1] = new_col[r];
        end
        res_flag_nxt = cvalid_r;
        if (inner_r) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end else begin
          res_value_nxt = '0;
          state_nxt     = S_OUT;
        end
      end
      S_MAC: begin
        // tap k is read into pix_sel_r and coef_rd_r, multiplied into prod_r, then added to acc_r
        if (int'(k_r) >= 2) begin
          acc_nxt = acc_r + n2dc_pkg::SUM_W'(prod_r);
        end
        k_nxt = k_r + n2dc_pkg::KCNT_W'(1);
        if (int'(k_r) == n2dc_pkg::MASK_SIZE + 1) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        neg_nxt   = acc_r[n2dc_pkg::SUM_W-1];
        quo_nxt   = acc_r[n2dc_pkg::SUM_W-1] ? n2dc_pkg::SUM_W'(-acc_r) :
                                               n2dc_pkg::SUM_W'(acc_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = div_ge ? div_diff[n2dc_pkg::NORM_W-1:0] :
                            div_trial[n2dc_pkg::NORM_W-1:0];
        quo_nxt  = {quo_r[n2dc_pkg::SUM_W-2:0], div_ge};
        dcnt_nxt = dcnt_r + n2dc_pkg::DCNT_W'(1);
        if (int'(dcnt_r) == n2dc_pkg::SUM_W - 1) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (q_signed > SAT_HI) begin
          res_value_nxt = n2dc_pkg::OUT_W'(SAT_HI);
        end else if (q_signed < SAT_LO) begin
          res_value_nxt = n2dc_pkg::OUT_W'(SAT_LO);
        end else begin
          res_value_nxt = n2dc_pkg::OUT_W'(q_signed);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_flag_nxt  = res_flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_fire) begin
      unique case (cfg_bus.index)
        n2dc_pkg::REG_WIDTH: begin
          width_nxt = cfg_w_eff;
          delay_nxt = n2dc_pkg::LEAD_W'(n2dc_pkg::HALF_H * int'(cfg_w_eff) +
                                        n2dc_pkg::HALF_W);
          col_nxt   = '0;
          lead_nxt  = '0;
          cx_nxt    = '0;
          cy_nxt    = '0;
        end
        n2dc_pkg::REG_HEIGHT: begin
          height_nxt = (cfg_h_raw == '0) ? n2dc_pkg::HEIGHT_W'(1) : cfg_h_raw;
          col_nxt    = '0;
          lead_nxt   = '0;
          cx_nxt     = '0;
          cy_nxt     = '0;
        end
        n2dc_pkg::REG_NORM: begin
          norm_nxt = (cfg_n_raw == '0) ? n2dc_pkg::NORM_W'(1) : cfg_n_raw;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r   <= wr_addr_nxt;
    px_r        <= px_nxt;
    cvalid_r    <= cvalid_nxt;
    inner_r     <= inner_nxt;
    pix_sel_r   <= pix_sel_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    neg_r       <= neg_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    res_value_r <= res_value_nxt;
    res_flag_r  <= res_flag_nxt;
    out_value_r <= out_value_nxt;
    out_flag_r  <= out_flag_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= n2dc_pkg::WEFF_W'(n2dc_pkg::RESET_WIDTH);
      height_r    <= n2dc_pkg::HEIGHT_W'(n2dc_pkg::RESET_HEIGHT);
      norm_r      <= n2dc_pkg::NORM_W'(n2dc_pkg::RESET_NORM);
      delay_r     <= n2dc_pkg::LEAD_W'(n2dc_pkg::HALF_H * n2dc_pkg::RESET_WIDTH +
                                       n2dc_pkg::HALF_W);
      lead_r      <= '0;
      col_r       <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      k_r         <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < n2dc_pkg::MASK_SIZE; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      norm_r      <= norm_nxt;
      delay_r     <= delay_nxt;
      lead_r      <= lead_nxt;
      col_r       <= col_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      k_r         <= k_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // line store: read at accept, written back in S_LOAD; the FSM keeps
  // the next read behind the write
  always_ff @(posedge clk) begin
    if (item_fire) begin
      line_rd_r <= line_mem[col_r];
    end
    if (line_wr_en) begin
      line_mem[wr_addr_r] <= line_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wr_en) begin
      coef_mem[in_bus.coef_index[n2dc_pkg::K_W-1:0]] <= in_bus.coef_value;
    end
    coef_rd_r <= coef_mem[k_idx];
  end

`ifndef ASSERT_OFF
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire |=> !in_bus.ready)
    else $error("input taken while a pixel word is in progress");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_flag_r) |-> (out_value_r == '0))
    else $error("word without a centre carries a nonzero value");

  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r <= delay_r)
    else $error("raster lead count passed the window delay");

  a_centre_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (n2dc_pkg::WEFF_W'(cx_r) < width_r) && (cy_r < height_r))
    else $error("centre position outside the image");
`endif

endmodule

`default_nettype wire
